// File: hw/rtl/nalsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsp_pkg: shared types and constants of the Annex B NAL unit splitter
// Holds the result record, the status codes and the header field masks.
// ----------------------------------------------------------------------------
package nalsp_pkg;

  // Width of the internal buffer position counter; offsets wrap at this width.
  localparam int OffsetBits = 24;
  // Width of the offset and length fields of a result.
  localparam int FieldW     = 24;

  localparam logic [6:0] TypeLimitReset = 7'd64;
  localparam logic [7:0] ForbiddenMask  = 8'h80;
  localparam logic [7:0] TypeMask       = 8'h7E;
  localparam logic [7:0] StartCodeLast  = 8'h01;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FORBIDDEN   = 3'd1,
    ST_TYPE_HIGH   = 3'd2,
    ST_ZERO_HEADER = 3'd3,
    ST_TRUNCATED   = 3'd4,
    ST_NO_START    = 3'd5
  } status_e;

  typedef struct packed {
    logic [5:0]        unit_type;
    status_e           unit_status;
    logic [2:0]        prefix_length;
    logic [FieldW-1:0] payload_offset;
    logic [FieldW-1:0] payload_length;
    logic              final_unit;
  } result_t;

  // Results produced by one accepted byte: count (0..2), then the records.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: hw/rtl/nalsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsp_in_if / nalsp_out_if: byte and result channels of the splitter
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface nalsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       buffer_end;

  modport source (output valid, output stream_byte, output buffer_end, input ready);
  modport sink   (input valid, input stream_byte, input buffer_end, output ready);
endinterface

interface nalsp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  unit_type;
  logic [2:0]  unit_status;
  logic [2:0]  prefix_length;
  logic [23:0] payload_offset;
  logic [23:0] payload_length;
  logic        final_unit;

  modport source (output valid, output unit_type, output unit_status,
                  output prefix_length, output payload_offset,
                  output payload_length, output final_unit, input ready);
  modport sink   (input valid, input unit_type, input unit_status,
                  input prefix_length, input payload_offset,
                  input payload_length, input final_unit, output ready);
endinterface

// File: hw/rtl/nalsp_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsp_result_fifo: four-entry result queue
// Takes up to two results per cycle, hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module nalsp_result_fifo
  import nalsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t    mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  assign space_o = (cnt_q <= 3'd2);
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q + push_i.cnt;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.r1;
    end
  end

endmodule

// File: hw/rtl/annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter: HEVC Annex B start code parser
// Scans one buffer a byte at a time, splits it at start codes and reports
// one result per NAL unit with its header check, prefix, offset and length.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has space; the scan
//   state updates on accept, so the next byte can follow in the next cycle.
// Output: a result is queued as the byte closing its unit is accepted and
//   shows once earlier results are taken. A byte may give two results; the
//   four-entry queue takes bytes while at most two results wait.
// Reset: asynchronous, active low; clears the scan state, the queue, and sets
//   type_limit to 64. The scan state also returns to reset after buffer_end.
module annexb_nal_unit_splitter
  import nalsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_data_i,
  nalsp_in_if.sink          in_i,
  nalsp_out_if.source       out_o
);

  // Scan phases.
  localparam logic [2:0] PhLead = 3'd0;  // expect leading start code
  localparam logic [2:0] PhSkip = 3'd1;  // drop bytes up to buffer end
  localparam logic [2:0] PhHdr0 = 3'd2;  // first header byte
  localparam logic [2:0] PhHdr1 = 3'd3;  // second header byte
  localparam logic [2:0] PhBody = 3'd4;  // payload scan

  logic [2:0]            phase_q, phase_d;
  logic [1:0]            zrun_q, zrun_d;
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [OffsetBits-1:0] pstart_q, pstart_d;
  logic [2:0]            prefix_q, prefix_d;
  logic [7:0]            hdr0_q, hdr0_d;
  status_e               held_q, held_d;
  logic [6:0]            type_limit_q;

  logic       accept;
  logic       fifo_space;
  push_t      push;
  result_t    head;
  logic [7:0] b;
  logic       last;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = fifo_space;
  assign b           = in_i.stream_byte;
  assign last        = in_i.buffer_end;

  // Build a result for a closed unit; type is shown only on a clean header.
  function automatic result_t unit_res(status_e st, logic [7:0] hdr, logic [2:0] pfx,
                                       logic [OffsetBits-1:0] start,
                                       logic [OffsetBits-1:0] close_at, logic fin);
    result_t r;
    logic [7:0] tbits;
    tbits            = (hdr & TypeMask) >> 1;
    r.unit_type      = (st == ST_OK) ? tbits[5:0] : 6'd0;
    r.unit_status    = st;
    r.prefix_length  = pfx;
    r.payload_offset = FieldW'(start);
    r.payload_length = FieldW'(close_at - start);
    r.final_unit     = fin;
    return r;
  endfunction

  // Header cut off by the buffer end: no length, always the last result.
  function automatic result_t trunc_res(logic [2:0] pfx, logic [OffsetBits-1:0] start);
    result_t r;
    r.unit_type      = 6'd0;
    r.unit_status    = ST_TRUNCATED;
    r.prefix_length  = pfx;
    r.payload_offset = FieldW'(start);
    r.payload_length = '0;
    r.final_unit     = 1'b1;
    return r;
  endfunction

  always_comb begin
    logic [2:0]            found;
    logic                  fail;
    logic [2:0]            sc_pfx;
    logic [7:0]            tbits;
    result_t               nostart;

    phase_d  = phase_q;
    zrun_d   = zrun_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    prefix_d = prefix_q;
    hdr0_d   = hdr0_q;
    held_d   = held_q;
    push     = '0;
    found    = 3'd0;
    fail     = 1'b0;
    sc_pfx   = 3'd3;
    tbits    = (hdr0_q & TypeMask) >> 1;

    nostart                = '0;
    nostart.unit_status    = ST_NO_START;
    nostart.final_unit     = 1'b1;

    if (accept) begin
      unique case (phase_q)
        PhLead: begin
          // Leading start code: 00 00 01 at offsets 0..2 or 00 00 00 01.
          if (pos_q <= OffsetBits'(1)) begin
            fail = (b != 8'h00);
          end else if (pos_q == OffsetBits'(2)) begin
            if (b == StartCodeLast) begin
              found = 3'd3;
            end else if (b != 8'h00) begin
              fail = 1'b1;
            end
          end else if (pos_q == OffsetBits'(3)) begin
            if (b == StartCodeLast) begin
              found = 3'd4;
            end else begin
              fail = 1'b1;
            end
          end else begin
            fail = 1'b1;
          end

          if (found != 3'd0) begin
            prefix_d = found;
            pstart_d = pos_q + OffsetBits'(3);
            zrun_d   = 2'd0;
            phase_d  = PhHdr0;
            if (last) begin
              push.cnt = 2'd1;
              push.r0  = trunc_res(found, pos_q + OffsetBits'(3));
            end
          end else if (fail || last) begin
            push.cnt = 2'd1;
            push.r0  = nostart;
            phase_d  = PhSkip;
          end
        end

        PhSkip: begin
          // Drop bytes until the buffer end resets the scan.
        end

        PhHdr0: begin
          hdr0_d  = b;
          phase_d = PhHdr1;
          if (last) begin
            push.cnt = 2'd1;
            push.r0  = trunc_res(prefix_q, pstart_q);
          end
        end

        PhHdr1: begin
          // Zero header first, then forbidden bit, then type limit.
          priority if (hdr0_q == 8'h00 && b == 8'h00) begin
            held_d = ST_ZERO_HEADER;
          end else if ((hdr0_q & ForbiddenMask) != 8'h00) begin
            held_d = ST_FORBIDDEN;
          end else if ({1'b0, tbits[5:0]} >= type_limit_q) begin
            held_d = ST_TYPE_HIGH;
          end else begin
            held_d = ST_OK;
          end
          zrun_d  = 2'd0;
          phase_d = PhBody;
          if (last) begin
            push.cnt = 2'd1;
            push.r0  = unit_res(held_d, hdr0_q, prefix_q, pstart_q,
                                pos_q + OffsetBits'(1), 1'b1);
          end
        end

        PhBody: begin
          if (b == StartCodeLast && zrun_q >= 2'd2) begin
            // Start code found: close the unit where its zeros began.
            sc_pfx   = (zrun_q == 2'd3) ? 3'd4 : 3'd3;
            push.cnt = 2'd1;
            push.r0  = unit_res(held_q, hdr0_q, prefix_q, pstart_q,
                                pos_q - OffsetBits'(sc_pfx) + OffsetBits'(1), 1'b0);
            prefix_d = sc_pfx;
            pstart_d = pos_q + OffsetBits'(3);
            zrun_d   = 2'd0;
            phase_d  = PhHdr0;
            if (last) begin
              push.cnt = 2'd2;
              push.r1  = trunc_res(sc_pfx, pos_q + OffsetBits'(3));
            end
          end else begin
            if (b == 8'h00) begin
              if (zrun_q != 2'd3) begin
                zrun_d = zrun_q + 2'd1;
              end
            end else begin
              zrun_d = 2'd0;
            end
            if (last) begin
              push.cnt = 2'd1;
              push.r0  = unit_res(held_q, hdr0_q, prefix_q, pstart_q,
                                  pos_q + OffsetBits'(1), 1'b1);
            end
          end
        end

        default: begin
          phase_d = PhSkip;
        end
      endcase

      // Advance the position, or return to reset state after the last byte.
      if (last) begin
        phase_d  = PhLead;
        zrun_d   = 2'd0;
        pos_d    = '0;
        pstart_d = '0;
        prefix_d = 3'd4;
        hdr0_d   = 8'h00;
        held_d   = ST_OK;
      end else begin
        pos_d = pos_q + OffsetBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhLead;
      zrun_q       <= 2'd0;
      pos_q        <= '0;
      pstart_q     <= '0;
      prefix_q     <= 3'd4;
      hdr0_q       <= 8'h00;
      held_q       <= ST_OK;
      type_limit_q <= TypeLimitReset;
    end else begin
      phase_q  <= phase_d;
      zrun_q   <= zrun_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      prefix_q <= prefix_d;
      hdr0_q   <= hdr0_d;
      held_q   <= held_d;
      if (cfg_we_i) begin
        type_limit_q <= cfg_data_i;
      end
    end
  end

  // Result queue parts the scan from the output handshake.
  nalsp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (fifo_space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  assign out_o.unit_type      = head.unit_type;
  assign out_o.unit_status    = head.unit_status;
  assign out_o.prefix_length  = head.prefix_length;
  assign out_o.payload_offset = head.payload_offset;
  assign out_o.payload_length = head.payload_length;
  assign out_o.final_unit     = head.final_unit;

endmodule

// File: hw/rtl/nalsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsp_checker: port-level checks of the splitter
// Watches the result channel and checks the shape of special results.
// ----------------------------------------------------------------------------
module nalsp_checker
  import nalsp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  unit_type_i,
  input logic [2:0]  unit_status_i,
  input logic [2:0]  prefix_length_i,
  input logic [23:0] payload_offset_i,
  input logic [23:0] payload_length_i,
  input logic        final_unit_i
);

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({unit_type_i, unit_status_i, prefix_length_i,
               payload_offset_i, payload_length_i, final_unit_i}))
    else $error("result changed while stalled");

  a_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unit_status_i == ST_NO_START |->
      final_unit_i && prefix_length_i == 3'd0 && payload_offset_i == 24'd0 &&
      payload_length_i == 24'd0)
    else $error("malformed no-start-code result");

  a_truncated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unit_status_i == ST_TRUNCATED |->
      final_unit_i && payload_length_i == 24'd0 &&
      (prefix_length_i == 3'd3 || prefix_length_i == 3'd4))
    else $error("malformed truncated-header result");

  a_type_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unit_status_i != ST_OK |-> unit_type_i == 6'd0)
    else $error("unit type shown on a failed header");

endmodule

bind annexb_nal_unit_splitter nalsp_checker u_nalsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .unit_type_i      (out_o.unit_type),
  .unit_status_i    (out_o.unit_status),
  .prefix_length_i  (out_o.prefix_length),
  .payload_offset_i (out_o.payload_offset),
  .payload_length_i (out_o.payload_length),
  .final_unit_i     (out_o.final_unit)
);

// File: bench/nalsp_unit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsp_unit_check: NAL unit predictor and result comparator
// Watches the byte and result channels and the type_limit port. It rebuilds
// the expected unit records from every accepted byte and compares each
// accepted result with the oldest record still waiting.
// ----------------------------------------------------------------------------
module nalsp_unit_check
  import nalsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  nalsp_in_if        in_mon,
  nalsp_out_if       out_mon,
  output int         fail_count_o,
  output int         expected_left_o
);

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_SKIP,
    SCAN_HDR0,
    SCAN_HDR1,
    SCAN_BODY
  } scan_e;

  // Shadow of the block's scan state.
  scan_e                 scan_phase;
  logic [1:0]            zeros_seen;
  logic [OffsetBits-1:0] byte_pos;
  logic [OffsetBits-1:0] payload_start;
  logic [2:0]            prefix_len;
  logic [7:0]            header_byte0;
  status_e               header_verdict;
  logic [6:0]            type_limit;

  result_t expected_units[$];
  result_t want;
  int      fail_count = 0;
  int      result_idx = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] result %0d: %s", $time, result_idx, msg);
  endtask

  task automatic push_result(input logic [5:0] utype, input status_e status,
                             input logic [2:0] prefix, input logic [OffsetBits-1:0] offset,
                             input logic [OffsetBits-1:0] length, input logic last_unit);
    result_t r;
    r.unit_type      = utype;
    r.unit_status    = status;
    r.prefix_length  = prefix;
    r.payload_offset = FieldW'(offset);
    r.payload_length = FieldW'(length);
    r.final_unit     = last_unit;
    expected_units.push_back(r);
  endtask

  task automatic push_truncated();
    push_result('0, ST_TRUNCATED, prefix_len, payload_start, '0, 1'b1);
  endtask

  // Close the open unit at close_at; the type is only shown for a clean header.
  task automatic push_unit(input logic [OffsetBits-1:0] close_at, input logic last_unit);
    logic [7:0] masked;
    masked = header_byte0 & TypeMask;
    push_result((header_verdict == ST_OK) ? masked[6:1] : 6'd0, header_verdict, prefix_len,
                payload_start, close_at - payload_start, last_unit);
  endtask

  task automatic open_header(input logic [2:0] prefix, input logic [OffsetBits-1:0] pos);
    prefix_len    = prefix;
    payload_start = pos + OffsetBits'(3);
    zeros_seen    = '0;
    scan_phase    = SCAN_HDR0;
  endtask

  task automatic clear_scan();
    scan_phase     = SCAN_LEAD;
    zeros_seen     = '0;
    byte_pos       = '0;
    payload_start  = '0;
    prefix_len     = 3'd4;
    header_byte0   = '0;
    header_verdict = ST_OK;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [OffsetBits-1:0] pos;
    logic [2:0]            found;
    logic [2:0]            sc_len;
    logic [7:0]            masked;
    logic                  bad;
    pos   = byte_pos;
    found = '0;
    bad   = 1'b0;
    case (scan_phase)
      SCAN_LEAD: begin
        if (pos <= 1) begin
          bad = (b != 8'h00);
        end else if (pos == 2) begin
          if (b == StartCodeLast) found = 3'd3;
          else if (b != 8'h00) bad = 1'b1;
        end else if (pos == 3) begin
          if (b == StartCodeLast) found = 3'd4;
          else bad = 1'b1;
        end else begin
          bad = 1'b1;
        end
        if (found != 0) begin
          open_header(found, pos);
          if (last) push_truncated();
        end else if (bad || last) begin
          push_result('0, ST_NO_START, '0, '0, '0, 1'b1);
          scan_phase = SCAN_SKIP;
        end
      end
      SCAN_SKIP: begin
      end
      SCAN_HDR0: begin
        header_byte0 = b;
        scan_phase   = SCAN_HDR1;
        if (last) push_truncated();
      end
      SCAN_HDR1: begin
        // Zero header wins over the forbidden bit, which wins over the type.
        masked = header_byte0 & TypeMask;
        if (header_byte0 == 8'h00 && b == 8'h00) header_verdict = ST_ZERO_HEADER;
        else if ((header_byte0 & ForbiddenMask) != 0) header_verdict = ST_FORBIDDEN;
        else if ({1'b0, masked[6:1]} >= type_limit) header_verdict = ST_TYPE_HIGH;
        else header_verdict = ST_OK;
        zeros_seen = '0;
        scan_phase = SCAN_BODY;
        if (last) push_unit(pos + OffsetBits'(1), 1'b1);
      end
      SCAN_BODY: begin
        if (b == StartCodeLast && zeros_seen >= 2) begin
          sc_len = (zeros_seen == 2'd3) ? 3'd4 : 3'd3;
          push_unit(pos - OffsetBits'(sc_len) + OffsetBits'(1), 1'b0);
          open_header(sc_len, pos);
          if (last) push_truncated();
        end else begin
          if (b == 8'h00) begin
            if (zeros_seen != 2'd3) zeros_seen++;
          end else begin
            zeros_seen = '0;
          end
          if (last) push_unit(pos + OffsetBits'(1), 1'b1);
        end
      end
      default: scan_phase = SCAN_SKIP;
    endcase
    if (last) clear_scan();
    else byte_pos = pos + OffsetBits'(1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_limit = TypeLimitReset;
      clear_scan();
      expected_units.delete();
      expected_left_o = 0;
    end else begin
      if (cfg_we_i) type_limit = cfg_data_i;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (status %0d, offset %0d)",
                                    out_mon.unit_status, out_mon.payload_offset));
        end else begin
          want = expected_units.pop_front();
          if (out_mon.unit_type !== want.unit_type)
            report_mismatch($sformatf("unit_type %0d, expected %0d",
                                      out_mon.unit_type, want.unit_type));
          if (out_mon.unit_status !== want.unit_status)
            report_mismatch($sformatf("unit_status %0d, expected %0d",
                                      out_mon.unit_status, want.unit_status));
          if (out_mon.prefix_length !== want.prefix_length)
            report_mismatch($sformatf("prefix_length %0d, expected %0d",
                                      out_mon.prefix_length, want.prefix_length));
          if (out_mon.payload_offset !== want.payload_offset)
            report_mismatch($sformatf("payload_offset %0d, expected %0d",
                                      out_mon.payload_offset, want.payload_offset));
          if (out_mon.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d, expected %0d",
                                      out_mon.payload_length, want.payload_length));
          if (out_mon.final_unit !== want.final_unit)
            report_mismatch($sformatf("final_unit %0d, expected %0d",
                                      out_mon.final_unit, want.final_unit));
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.stream_byte, in_mon.buffer_end);
      expected_left_o = expected_units.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the Annex B NAL unit splitter
// Feeds directed buffers and then random buffers, mostly well-formed start
// code / header / payload sequences, under four idling profiles and several
// type_limit settings. A companion unit check predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import nalsp_pkg::*;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [6:0] cfg_data_i;

  nalsp_in_if  in_ch ();
  nalsp_out_if out_ch ();

  int fail_count;
  int expected_left;

  // Idling knobs, percent of cycles: sender gap and receiver stall.
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  // Long receiver hold-off, triggered once from the stimulus.
  logic hold_go       = 1'b0;
  logic hold_off      = 1'b0;

  int         random_bytes_sent = 0;
  logic [7:0] buffer_q[$];

  annexb_nal_unit_splitter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  nalsp_unit_check i_unit_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left)
  );

  // 2 ns clock: 1 ns high, 1 ns low.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: decide ready at every falling edge; hold it low during hold-off.
  always @(negedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Hold the receiver off for a long stretch so the result queue fills up
  // and the block has to stall its byte input.
  initial begin
    wait (hold_go);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Safety net: end the run if the block hangs.
  initial begin
    #400000;
    $display("annexb_nal_unit_splitter regression: fail");
    $finish;
  end

  // Send buffer_q as one buffer, buffer_end on its last byte. Each byte is
  // one transaction; the sender may idle before offering it.
  task automatic send_buffer();
    for (int k = 0; k < buffer_q.size(); k++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
      in_ch.valid       <= 1'b1;
      in_ch.stream_byte <= buffer_q[k];
      in_ch.buffer_end  <= (k == buffer_q.size() - 1);
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    random_bytes_sent += buffer_q.size();
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  // so a register write cannot overlap work on an item with no result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_left != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_type_limit(input logic [6:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Zero-biased payload byte so start codes and zero runs show up often.
  function automatic logic [7:0] payload_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return 8'h00;
    if (pick == 4) return StartCodeLast;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int         n_units;
    int         pay_len;
    int         pick;
    int         keep;
    logic [7:0] hdr0;
    logic [6:0] limits[4];

    in_ch.valid       = 1'b0;
    in_ch.stream_byte = '0;
    in_ch.buffer_end  = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part, type_limit 40 ----
    write_type_limit(7'd40);
    // Four-byte start code, forbidden bit header, empty payload closed by a
    // three-byte start code, zero header, type above the limit, then a
    // payload with trailing zeros running to the buffer end.
    buffer_q = {8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h01,
                8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h01, 8'h7E, 8'h01,
                8'hFF, 8'h00, 8'h00};
    send_buffer();
    // No leading start code.
    buffer_q = {8'h05};
    send_buffer();
    // Buffer ends before the start code is complete.
    buffer_q = {8'h00, 8'h00};
    send_buffer();
    // Buffer ends on the start code's last byte: truncated header.
    buffer_q = {8'h00, 8'h00, 8'h01};
    send_buffer();
    drain();

    // ---- random part: four idling profiles, one type_limit each ----
    limits[0] = TypeLimitReset;
    limits[1] = 7'd0;
    limits[2] = 7'($urandom_range(1, 63));
    limits[3] = 7'd63;
    random_bytes_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      write_type_limit(limits[ph]);
      if (ph == 0) hold_go = 1'b1;
      while (random_bytes_sent < (ph + 1) * 262) begin
        buffer_q = {};
        if ($urandom_range(99) < 8) begin
          // Noise: short buffer that rarely opens with a start code.
          repeat ($urandom_range(1, 6)) buffer_q.push_back(payload_byte());
        end else begin
          n_units = $urandom_range(1, 4);
          for (int u = 0; u < n_units; u++) begin
            if ($urandom_range(1) == 1) buffer_q.push_back(8'h00);
            buffer_q.push_back(8'h00);
            buffer_q.push_back(8'h00);
            buffer_q.push_back(StartCodeLast);
            pick = $urandom_range(99);
            if (pick < 6) begin
              buffer_q.push_back(8'h00);
              buffer_q.push_back(8'h00);
            end else begin
              if (pick < 14) hdr0 = ForbiddenMask | 8'($urandom_range(255));
              else hdr0 = 8'($urandom_range(127));
              buffer_q.push_back(hdr0);
              buffer_q.push_back(8'($urandom_range(255)));
            end
            // Mostly short payloads, now and then a longer one.
            pay_len = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
            repeat (pay_len) buffer_q.push_back(payload_byte());
          end
          // Trailing zeros that do not complete a start code.
          if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) buffer_q.push_back(8'h00);
          // Cut the buffer short: lands anywhere, headers and start codes too.
          if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, buffer_q.size());
            while (buffer_q.size() > keep) void'(buffer_q.pop_back());
          end
        end
        send_buffer();
      end
      drain();
    end

    if (fail_count == 0 && expected_left == 0) begin
      $display("annexb_nal_unit_splitter regression: pass");
    end else begin
      $display("annexb_nal_unit_splitter regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/nalsp_pkg.sv
hw/rtl/nalsp_if.sv
hw/rtl/nalsp_result_fifo.sv
hw/rtl/annexb_nal_unit_splitter.sv
hw/rtl/nalsp_checker.sv
bench/nalsp_unit_check.sv
bench/testbench.sv
